// ===== hw/rtl/msbr_pkg.sv =====
// Shared constants and types of the MSB-first bit reader.
`default_nettype none

package msbr_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int MAX_READ_BITS = 64;

  localparam int QAW    = $clog2(QUEUE_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int VAL_SHW = $clog2(MAX_READ_BITS);

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_SKIP = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic start;
    logic step;
    logic emit;
  } msbr_cmd_t;

  typedef struct packed {
    logic last;
  } msbr_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msbr_dp.sv =====
// Datapath of the MSB-first bit reader: byte queue, bit extraction and result register.
`default_nettype none

module msbr_dp import msbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  msbr_cmd_t   cmd_i,
  output msbr_sts_t   sts_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [6:0]  bit_count_i,
  output logic [63:0] field_value_o,
  output logic [6:0]  bits_delivered_o,
  output logic [1:0]  status_o
);

  logic [1:0]     op_q, op_d;
  logic [7:0]     data_q, data_d;
  logic [6:0]     count_q, count_d;
  logic [6:0]     rem_q, rem_d;
  logic [63:0]    val_q, val_d;
  logic [6:0]     got_q, got_d;
  logic [1:0]     st_q, st_d;

  logic [7:0]     mem_q [QUEUE_DEPTH];
  logic           wr_en;
  logic [QAW-1:0] head_q, head_d;
  logic [QAW-1:0] tail_q, tail_d;
  logic [QCW-1:0] qcnt_q, qcnt_d;
  logic [7:0]     cur_q, cur_d;
  logic [3:0]     left_q, left_d;

  logic [63:0]    out_val_q;
  logic [6:0]     out_got_q;
  logic [1:0]     out_st_q;

  logic           queue_empty;
  logic           queue_full;
  logic           need_load;
  logic [7:0]     avail_byte;
  logic [3:0]     avail_bits;
  logic [3:0]     take;
  logic [3:0]     keep;
  logic [6:0]     rem_next;
  logic [7:0]     mask;
  logic [7:0]     chunk;
  logic           range_err;
  logic           last;

  assign queue_empty = (qcnt_q == '0);
  assign queue_full  = (qcnt_q == QCW'(QUEUE_DEPTH));
  assign need_load   = (left_q == 4'd0);
  assign avail_byte  = need_load ? mem_q[head_q] : cur_q;
  assign avail_bits  = need_load ? 4'd8 : left_q;
  assign take        = (rem_q < 7'(avail_bits)) ? rem_q[3:0] : avail_bits;
  assign keep        = avail_bits - take;
  assign rem_next    = rem_q - 7'(take);
  assign mask        = 8'hFF >> (4'd8 - take);
  assign chunk       = (avail_byte >> keep) & mask;
  assign range_err   = (count_q > 7'(MAX_READ_BITS));

  always_comb begin
    op_d    = op_q;
    data_d  = data_q;
    count_d = count_q;
    rem_d   = rem_q;
    val_d   = val_q;
    got_d   = got_q;
    st_d    = st_q;
    head_d  = head_q;
    tail_d  = tail_q;
    qcnt_d  = qcnt_q;
    cur_d   = cur_q;
    left_d  = left_q;
    wr_en   = 1'b0;
    last    = 1'b0;

    if (cmd_i.start) begin
      op_d    = op_i;
      data_d  = data_byte_i;
      count_d = bit_count_i;
      rem_d   = bit_count_i;
      val_d   = '0;
      got_d   = '0;
      st_d    = ST_OK;
    end

    if (cmd_i.step) begin
      case (op_q)
        OP_PUSH: begin
          last = 1'b1;
          if (queue_full) begin
            st_d = ST_FULL;
          end else begin
            wr_en  = 1'b1;
            tail_d = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QAW'(1);
            qcnt_d = qcnt_q + QCW'(1);
          end
        end
        OP_READ: begin
          if (range_err) begin
            st_d = ST_RANGE;
            last = 1'b1;
          end else if (rem_q == '0) begin
            last = 1'b1;
          end else if (need_load && queue_empty) begin
            st_d = ST_SHORT;
            last = 1'b1;
          end else begin
            if (need_load) begin
              head_d = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
              qcnt_d = qcnt_q - QCW'(1);
            end
            cur_d  = avail_byte;
            left_d = keep;
            val_d  = val_q | (64'(chunk) << rem_next[VAL_SHW-1:0]);
            got_d  = got_q + 7'(take);
            rem_d  = rem_next;
            last   = (rem_next == '0);
          end
        end
        OP_SKIP: begin
          last = 1'b1;
          if (left_q != 4'd0 && left_q != 4'd8) begin
            left_d = 4'd0;
          end
        end
        default: begin
          last = 1'b1;
        end
      endcase
    end
  end

  assign sts_o.last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      qcnt_q <= '0;
      cur_q  <= '0;
      left_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      qcnt_q <= qcnt_d;
      cur_q  <= cur_d;
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    data_q  <= data_d;
    count_q <= count_d;
    rem_q   <= rem_d;
    val_q   <= val_d;
    got_q   <= got_d;
    st_q    <= st_d;
    if (wr_en) begin
      mem_q[tail_q] <= data_q;
    end
    if (cmd_i.emit) begin
      out_val_q <= val_q;
      out_got_q <= got_q;
      out_st_q  <= st_q;
    end
  end

  assign field_value_o    = out_val_q;
  assign bits_delivered_o = out_got_q;
  assign status_o         = out_st_q;

endmodule

`default_nettype wire

// ===== hw/rtl/msbr_ctrl.sv =====
// Controller state machine of the MSB-first bit reader.
`default_nettype none

module msbr_ctrl import msbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output msbr_cmd_t cmd_o,
  input  msbr_sts_t sts_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msb_first_bit_reader.sv =====
// Top level of the MSB-first bit reader over a byte queue.
// Each word is accepted in S_IDLE, steps in S_STEP and is moved to the output register in
// S_OUT, which waits for a pending result to be taken: push, skip, zero-bit and rejected
// reads end on their first step, and a read of N bits takes one step per byte touched and
// one more if the queue runs dry. A new word is accepted once the previous one is in the
// output register. Reset empties the queue, drops the current byte and idles the controller.
`default_nettype none

module msb_first_bit_reader import msbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [6:0]  bit_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] field_value_o,
  output logic [6:0]  bits_delivered_o,
  output logic [1:0]  status_o
);

  msbr_cmd_t cmd;
  msbr_sts_t sts;

  msbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  msbr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .data_byte_i      (data_byte_i),
    .bit_count_i      (bit_count_i),
    .field_value_o    (field_value_o),
    .bits_delivered_o (bits_delivered_o),
    .status_o         (status_o)
  );

endmodule

`default_nettype wire
